### hw/rtl/ccc_pkg.sv
// ----------------------------------------------------------------------------
// ccc_pkg
// Shared widths, constants and types for the connected component counter.
// ----------------------------------------------------------------------------
package ccc_pkg;

  // Field widths fixed by the interface
  localparam int IDX_W    = 8;
  localparam int VC_W     = 9;
  localparam int PCOUNT_W = 9;
  localparam int RANK_W   = 4;

  localparam logic [VC_W-1:0]   VC_RESET = 9'd256;
  localparam logic [RANK_W-1:0] RANK_MAX = 4'd15;

  // Default forest size
  localparam int MAX_VERTICES_DEF = 256;

  // Command queue depth between front and back
  localparam int QDEPTH = 2;
  localparam int QPW    = 1;

  // One classified command handed from front to back
  typedef struct packed {
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic             do_join;
    logic             do_count;
  } ccc_cmd_t;

  // Back-end engine states
  typedef enum logic [2:0] {
    B_INIT,
    B_IDLE,
    B_FIND,
    B_COMP,
    B_LINK,
    B_BUMP,
    B_SWEEP_RD,
    B_SWEEP
  } ccc_state_t;

endpackage

### hw/rtl/ccc_front.sv
// ----------------------------------------------------------------------------
// ccc_front
// Holds the vertex count register, accepts matrix entries and classifies
// each one into a join and/or count command for the back end.
// ----------------------------------------------------------------------------
module ccc_front #(
  parameter int MAX_VERTICES = ccc_pkg::MAX_VERTICES_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic [ccc_pkg::IDX_W-1:0]  row,
  input  logic [ccc_pkg::IDX_W-1:0]  col,
  input  logic                       connected,
  input  logic                       last,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [ccc_pkg::VC_W-1:0]   vertex_count,
  output logic [ccc_pkg::VC_W-1:0]   vc_reg,
  input  logic                       q_full,
  input  logic                       init_busy,
  output logic                       push,
  output ccc_pkg::ccc_cmd_t          push_cmd
);
  import ccc_pkg::*;

  logic accept;
  logic row_ok;
  logic col_ok;

  // Take configuration writes at any time; the register is plain storage
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vc_reg <= VC_RESET;
    end else if (cfg_valid && cfg_ready) begin
      vc_reg <= vertex_count;
    end
  end

  // Stall while the queue is full or the forest is being initialized
  assign busy   = q_full | init_busy;
  assign accept = start & ~busy;

  // A vertex is in range when below both the register and the forest size
  assign row_ok = (32'(row) < 32'(vc_reg)) && (32'(row) < 32'(MAX_VERTICES));
  assign col_ok = (32'(col) < 32'(vc_reg)) && (32'(col) < 32'(MAX_VERTICES));

  // Classify; drop transactions that neither join nor count
  always_comb begin
    push_cmd.row      = row;
    push_cmd.col      = col;
    push_cmd.do_join  = connected & row_ok & col_ok;
    push_cmd.do_count = last;
    push              = accept & (push_cmd.do_join | push_cmd.do_count);
  end

endmodule

### hw/rtl/ccc_queue.sv
// ----------------------------------------------------------------------------
// ccc_queue
// Short command queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module ccc_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  ccc_pkg::ccc_cmd_t push_cmd,
  input  logic              pop,
  output ccc_pkg::ccc_cmd_t head,
  output logic              empty,
  output logic              full
);
  import ccc_pkg::*;

  ccc_cmd_t           slots [QDEPTH];
  logic [QPW-1:0]     wr_ptr;
  logic [QPW-1:0]     rd_ptr;
  logic [QPW:0]       fill;

  assign empty = (fill == '0);
  assign full  = (fill == (QPW+1)'(QDEPTH));
  assign head  = slots[rd_ptr];

  // Store incoming commands
  always_ff @(posedge clk) begin
    if (push && !full) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= (wr_ptr == QPW'(QDEPTH-1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop && !empty) begin
        rd_ptr <= (rd_ptr == QPW'(QDEPTH-1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push && !full, pop && !empty})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

### hw/rtl/ccc_back.sv
// ----------------------------------------------------------------------------
// ccc_back
// Union-find engine: walks parent chains in the forest memory, compresses
// them, links roots by rank, and sweeps the forest to count and clear.
// ----------------------------------------------------------------------------
module ccc_back #(
  parameter int MAX_VERTICES = ccc_pkg::MAX_VERTICES_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  ccc_pkg::ccc_cmd_t            head,
  input  logic                         q_empty,
  output logic                         pop,
  input  logic [ccc_pkg::VC_W-1:0]     vc_reg,
  output logic                         init_busy,
  output logic                         done,
  output logic [ccc_pkg::PCOUNT_W-1:0] province_count
);
  import ccc_pkg::*;

  localparam int VW = $clog2(MAX_VERTICES);
  localparam int EW = VW + RANK_W;
  localparam logic [VW-1:0] LAST_IDX = VW'(MAX_VERTICES - 1);

  ccc_state_t state, state_next;

  // Forest memory: {rank, parent} per vertex
  logic [EW-1:0]     forest [MAX_VERTICES];
  logic [EW-1:0]     rdata;
  logic [VW-1:0]     rd_addr;
  logic              we;
  logic [VW-1:0]     wa;
  logic [EW-1:0]     wd;

  logic [VW-1:0]     rd_par;
  logic [RANK_W-1:0] rd_rank;

  // Datapath registers
  logic [VW-1:0]       cur;
  logic [VW-1:0]       xstart;
  logic [VW-1:0]       root;
  logic [VW-1:0]       ra;
  logic [RANK_W-1:0]   rank_a;
  logic [RANK_W-1:0]   rank_b;
  logic                sel;
  logic [VW-1:0]       item_col;
  logic                item_last;
  logic [VW-1:0]       idx;
  logic [PCOUNT_W-1:0] count;
  logic [PCOUNT_W-1:0] count_next;
  logic                is_root;
  logic [RANK_W-1:0]   rank_bump;

  assign rd_par  = rdata[VW-1:0];
  assign rd_rank = rdata[EW-1:VW];

  assign init_busy = (state == B_INIT);

  // Root test during the sweep, limited to active vertices
  assign is_root    = (32'(idx) < 32'(vc_reg)) && (rd_par == idx);
  assign count_next = count + PCOUNT_W'(is_root);
  assign rank_bump  = (rank_a == RANK_MAX) ? rank_a : rank_a + 1'b1;

  // Memory port: one write, one registered read
  always_ff @(posedge clk) begin
    if (we) begin
      forest[wa] <= wd;
    end
    rdata <= forest[rd_addr];
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      B_INIT: begin
        if (idx == LAST_IDX) state_next = B_IDLE;
      end
      B_IDLE: begin
        if (!q_empty) state_next = head.do_join ? B_FIND : B_SWEEP_RD;
      end
      B_FIND: begin
        if (rd_par == cur) state_next = B_COMP;
      end
      B_COMP: begin
        if (cur == root) state_next = sel ? B_LINK : B_FIND;
      end
      B_LINK: begin
        if (ra != root && rank_a == rank_b) begin
          state_next = B_BUMP;
        end else begin
          state_next = item_last ? B_SWEEP_RD : B_IDLE;
        end
      end
      B_BUMP: begin
        state_next = item_last ? B_SWEEP_RD : B_IDLE;
      end
      B_SWEEP_RD: begin
        state_next = B_SWEEP;
      end
      B_SWEEP: begin
        if (idx == LAST_IDX) state_next = B_IDLE;
      end
      default: state_next = B_INIT;
    endcase
  end

  // Memory controls and queue pop
  always_comb begin
    pop     = 1'b0;
    rd_addr = '0;
    we      = 1'b0;
    wa      = '0;
    wd      = '0;
    case (state)
      B_INIT: begin
        we = 1'b1;
        wa = idx;
        wd = {{RANK_W{1'b0}}, idx};
      end
      B_IDLE: begin
        pop     = ~q_empty;
        rd_addr = VW'(head.row);
      end
      B_FIND: begin
        rd_addr = (rd_par == cur) ? xstart : rd_par;
      end
      B_COMP: begin
        if (cur == root) begin
          rd_addr = item_col;
        end else begin
          // point this chain vertex straight at the root
          we      = 1'b1;
          wa      = cur;
          wd      = {rd_rank, root};
          rd_addr = rd_par;
        end
      end
      B_LINK: begin
        if (ra != root) begin
          we = 1'b1;
          if (rank_a < rank_b) begin
            wa = ra;
            wd = {rank_a, root};
          end else begin
            wa = root;
            wd = {rank_b, ra};
          end
        end
      end
      B_BUMP: begin
        we = 1'b1;
        wa = ra;
        wd = {rank_bump, ra};
      end
      B_SWEEP_RD: begin
        rd_addr = '0;
      end
      B_SWEEP: begin
        we      = 1'b1;
        wa      = idx;
        wd      = {{RANK_W{1'b0}}, idx};
        rd_addr = idx + 1'b1;
      end
      default: begin
        rd_addr = '0;
      end
    endcase
  end

  // State and result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_INIT;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == B_SWEEP) && (idx == LAST_IDX);
    end
  end

  // Sweep index: init clear and count sweep
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else begin
      case (state)
        B_INIT, B_SWEEP: idx <= (idx == LAST_IDX) ? '0 : idx + 1'b1;
        B_SWEEP_RD:      idx <= '0;
        default:         idx <= idx;
      endcase
    end
  end

  // Walk, link and count datapath
  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        if (!q_empty) begin
          item_col  <= VW'(head.col);
          item_last <= head.do_count;
          cur       <= VW'(head.row);
          xstart    <= VW'(head.row);
          sel       <= 1'b0;
        end
      end
      B_FIND: begin
        if (rd_par == cur) begin
          root <= cur;
          cur  <= xstart;
        end else begin
          cur <= rd_par;
        end
      end
      B_COMP: begin
        if (cur == root) begin
          if (!sel) begin
            ra     <= root;
            rank_a <= rd_rank;
            sel    <= 1'b1;
            cur    <= item_col;
            xstart <= item_col;
          end else begin
            rank_b <= rd_rank;
          end
        end else begin
          cur <= rd_par;
        end
      end
      B_SWEEP_RD: begin
        count <= '0;
      end
      B_SWEEP: begin
        count <= count_next;
        if (idx == LAST_IDX) begin
          province_count <= count_next;
        end
      end
      default: begin
        cur <= cur;
      end
    endcase
  end

endmodule

### hw/rtl/connected_component_counter_core.sv
// ----------------------------------------------------------------------------
// connected_component_counter_core
// Counts connected components of a graph streamed as adjacency matrix entries.
// ----------------------------------------------------------------------------
// Operation: after reset the block holds busy while it sets the forest
// memory to identity. An entry that is neither a join nor last is dropped
// at the front. A join walks the parent chain of each of the two vertices
// in the back end, plus a rank bump step when the two roots have equal
// rank; each walk step is one read of the forest memory, and the chain is
// walked once to find the root and once to compress it. Union by rank keeps
// a chain at most log2 of the vertex count long and compression keeps most
// chains at one or two steps. An entry marked last adds a sweep through the
// memory that counts roots and clears the forest; done pulses for one cycle
// at the end of the sweep with province_count. A two entry queue lets new
// entries be taken while the back end works; after initialization busy rises
// only when it is full. Results cannot be stalled: capture province_count
// in the cycle done is high.
module connected_component_counter_core #(
  parameter int MAX_VERTICES = ccc_pkg::MAX_VERTICES_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [ccc_pkg::IDX_W-1:0]    row,
  input  logic [ccc_pkg::IDX_W-1:0]    col,
  input  logic                         connected,
  input  logic                         last,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [ccc_pkg::VC_W-1:0]     vertex_count,
  output logic                         done,
  output logic [ccc_pkg::PCOUNT_W-1:0] province_count
);
  import ccc_pkg::*;

  logic [VC_W-1:0] vc_reg;
  logic            q_full;
  logic            q_empty;
  logic            init_busy;
  logic            push;
  logic            pop;
  ccc_cmd_t        push_cmd;
  ccc_cmd_t        head;

  // Accept and classify entries
  ccc_front #(
    .MAX_VERTICES(MAX_VERTICES)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .row         (row),
    .col         (col),
    .connected   (connected),
    .last        (last),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .vertex_count(vertex_count),
    .vc_reg      (vc_reg),
    .q_full      (q_full),
    .init_busy   (init_busy),
    .push        (push),
    .push_cmd    (push_cmd)
  );

  // Buffer commands between front and back
  ccc_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_cmd(push_cmd),
    .pop     (pop),
    .head    (head),
    .empty   (q_empty),
    .full    (q_full)
  );

  // Execute joins and count sweeps
  ccc_back #(
    .MAX_VERTICES(MAX_VERTICES)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .q_empty       (q_empty),
    .pop           (pop),
    .vc_reg        (vc_reg),
    .init_busy     (init_busy),
    .done          (done),
    .province_count(province_count)
  );

endmodule

### hw/rtl/ccc_checker.sv
// ----------------------------------------------------------------------------
// ccc_checker
// Port-level checks for the connected component counter, bound to the core.
// ----------------------------------------------------------------------------
module ccc_checker #(
  parameter int MAX_VERTICES = ccc_pkg::MAX_VERTICES_DEF
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         busy,
  input logic                         done,
  input logic [ccc_pkg::PCOUNT_W-1:0] province_count
);
  import ccc_pkg::*;

  // Forest initialization holds off transactions right after reset
  a_busy_after_reset: assert property (@(posedge clk)
    !rst && $past(rst) |-> busy)
    else $error("busy low in the cycle after reset");

  // A count sweep spans the whole forest, so results never come back to back
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done high in two consecutive cycles");

  // No more components than vertices in the forest
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    done |-> (32'(province_count) <= 32'(MAX_VERTICES)))
    else $error("province_count exceeds forest size");

  // No result straight out of reset
  a_no_done_after_reset: assert property (@(posedge clk)
    !rst && $past(rst) |-> !done)
    else $error("done high in the cycle after reset");

endmodule

bind connected_component_counter_core ccc_checker #(
  .MAX_VERTICES(MAX_VERTICES)
) u_ccc_checker (
  .clk           (clk),
  .rst           (rst),
  .busy          (busy),
  .done          (done),
  .province_count(province_count)
);

### test/tb_connected_component_counter_core.sv
// ----------------------------------------------------------------------------
// tb_connected_component_counter_core
// Self-checking bench for the connected component counter. It streams
// adjacency matrix entries into the core and keeps its own union-find forest
// in step with every accepted transaction. Each province count the core
// reports is compared with the oldest count still pending. A short table of
// directed entries comes first. Random graphs follow, run in phases that
// change the vertex count and the sender idle rate.
// ----------------------------------------------------------------------------
module tb_connected_component_counter_core;
  timeunit 1ns;
  timeprecision 1ps;

  import ccc_pkg::*;

  localparam int    NV          = MAX_VERTICES_DEF;
  localparam real   CLK_PERIOD  = 8.0;
  localparam int    RESET_CYC   = 7;
  localparam int    DRAIN_CYC   = 600;
  localparam int    RAND_ITEMS  = 1550;
  localparam int    MAX_REPORTS = 20;
  localparam real   LIMIT_NS    = 50.0e6;
  localparam int    PEND_DEPTH  = 4096;

  // Clock, reset and core ports
  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic                busy;
  logic [IDX_W-1:0]    row = '0;
  logic [IDX_W-1:0]    col = '0;
  logic                connected = 1'b0;
  logic                last = 1'b0;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [VC_W-1:0]     vertex_count = VC_RESET;
  logic                done;
  logic [PCOUNT_W-1:0] province_count;

  // Predicted forest and the vertex count it was loaded with
  logic [IDX_W-1:0]    forest_parent [NV];
  logic [RANK_W-1:0]   forest_rank   [NV];
  logic [VC_W-1:0]     loaded_vc;

  // Province counts waiting for the core to report them, oldest at pend_rd
  logic [PCOUNT_W-1:0] pending_counts [PEND_DEPTH];
  int                  pend_wr = 0;
  int                  pend_rd = 0;
  int                  mismatch_count = 0;
  int                  random_sent = 0;

  // One directed entry: optional register write ahead of it, optional fixed count
  typedef struct packed {
    logic                wr_vc;
    logic [VC_W-1:0]     vc;
    logic [IDX_W-1:0]    r;
    logic [IDX_W-1:0]    c;
    logic                conn;
    logic                lst;
    logic                fixed;
    logic [PCOUNT_W-1:0] want;
  } directed_entry_t;

  localparam int N_DIRECTED = 23;
  directed_entry_t directed_entries [N_DIRECTED] = '{
    // nothing joined, count at reset size
    '{1'b0, 9'd0,   8'd0,   8'd0,   1'b0, 1'b1, 1'b1, 9'd256},
    // extremes joined, then a self join on the last entry
    '{1'b0, 9'd0,   8'd0,   8'd255, 1'b1, 1'b0, 1'b0, 9'd0},
    '{1'b0, 9'd0,   8'd255, 8'd255, 1'b1, 1'b1, 1'b1, 9'd255},
    // zero vertex count ignores every entry
    '{1'b1, 9'd0,   8'd5,   8'd7,   1'b1, 1'b1, 1'b1, 9'd0},
    // single vertex, second entry out of range
    '{1'b1, 9'd1,   8'd0,   8'd0,   1'b1, 1'b0, 1'b0, 9'd0},
    '{1'b0, 9'd0,   8'd0,   8'd1,   1'b1, 1'b1, 1'b1, 9'd1},
    // oversized count clamps to the forest size; repeated join is a no-op
    '{1'b1, 9'd511, 8'd255, 8'd0,   1'b1, 1'b0, 1'b0, 9'd0},
    '{1'b0, 9'd0,   8'd0,   8'd255, 1'b1, 1'b0, 1'b0, 9'd0},
    '{1'b0, 9'd0,   8'd1,   8'd2,   1'b0, 1'b1, 1'b1, 9'd255},
    // out-of-range last entry still counts and clears
    '{1'b1, 9'd4,   8'd3,   8'd4,   1'b1, 1'b1, 1'b1, 9'd4},
    // join on the last entry lands before the count
    '{1'b0, 9'd0,   8'd0,   8'd1,   1'b1, 1'b0, 1'b0, 9'd0},
    '{1'b0, 9'd0,   8'd2,   8'd3,   1'b1, 1'b0, 1'b0, 9'd0},
    '{1'b0, 9'd0,   8'd1,   8'd3,   1'b1, 1'b1, 1'b1, 9'd1},
    // vertex count shrinks in the middle of a graph
    '{1'b1, 9'd8,   8'd0,   8'd7,   1'b1, 1'b0, 1'b0, 9'd0},
    '{1'b0, 9'd0,   8'd5,   8'd6,   1'b1, 1'b0, 1'b0, 9'd0},
    '{1'b1, 9'd6,   8'd1,   8'd2,   1'b1, 1'b1, 1'b0, 9'd0},
    // deeper trees on the full forest
    '{1'b1, 9'd256, 8'd128, 8'd64,  1'b1, 1'b0, 1'b0, 9'd0},
    '{1'b0, 9'd0,   8'd200, 8'd100, 1'b1, 1'b0, 1'b0, 9'd0},
    '{1'b0, 9'd0,   8'd64,  8'd100, 1'b1, 1'b0, 1'b0, 9'd0},
    '{1'b0, 9'd0,   8'd128, 8'd200, 1'b1, 1'b0, 1'b0, 9'd0},
    '{1'b0, 9'd0,   8'd255, 8'd254, 1'b0, 1'b0, 1'b0, 9'd0},
    '{1'b0, 9'd0,   8'd100, 8'd255, 1'b1, 1'b1, 1'b0, 9'd0},
    '{1'b1, 9'd2,   8'd1,   8'd0,   1'b1, 1'b1, 1'b1, 9'd1}
  };

  connected_component_counter_core dut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .row            (row),
    .col            (col),
    .connected      (connected),
    .last           (last),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .vertex_count   (vertex_count),
    .done           (done),
    .province_count (province_count)
  );

  always #(CLK_PERIOD / 2.0) clk = ~clk;

  // Number of vertices that take part, clamped to the forest size
  function automatic int active_vertices();
    return (loaded_vc > NV) ? NV : int'(loaded_vc);
  endfunction

  // Return every vertex to its own set with rank zero
  function automatic void forest_clear();
    for (int i = 0; i < NV; i++) begin
      forest_parent[i] = IDX_W'(i);
      forest_rank[i]   = '0;
    end
  endfunction

  // Walk to the root, then point every vertex on the chain straight at it
  function automatic logic [IDX_W-1:0] root_compress(logic [IDX_W-1:0] v);
    logic [IDX_W-1:0] root;
    logic [IDX_W-1:0] cur;
    logic [IDX_W-1:0] nxt;
    root = v;
    for (int s = 0; s < NV && forest_parent[root] != root; s++)
      root = forest_parent[root];
    cur = v;
    for (int s = 0; s < NV && cur != root; s++) begin
      nxt = forest_parent[cur];
      forest_parent[cur] = root;
      cur = nxt;
    end
    return root;
  endfunction

  // Link two roots by rank; a shared root changes nothing
  function automatic void union_by_rank(logic [IDX_W-1:0] a, logic [IDX_W-1:0] b);
    logic [IDX_W-1:0] ra;
    logic [IDX_W-1:0] rb;
    ra = root_compress(a);
    rb = root_compress(b);
    if (ra == rb)
      return;
    if (forest_rank[ra] < forest_rank[rb]) begin
      forest_parent[ra] = rb;
    end else if (forest_rank[rb] < forest_rank[ra]) begin
      forest_parent[rb] = ra;
    end else begin
      forest_parent[rb] = ra;
      if (forest_rank[ra] < RANK_MAX)
        forest_rank[ra] = forest_rank[ra] + 1'b1;
    end
  endfunction

  // Apply one entry to the forest; return 1 with the count when it closes a graph
  function automatic logic absorb_entry(logic [IDX_W-1:0] r, logic [IDX_W-1:0] c,
                                        logic conn, logic lst,
                                        output logic [PCOUNT_W-1:0] roots);
    int n;
    int cnt;
    n = active_vertices();
    cnt = 0;
    roots = '0;
    if (conn && r < n && c < n)
      union_by_rank(r, c);
    if (!lst)
      return 1'b0;
    for (int i = 0; i < n; i++)
      if (forest_parent[i] == IDX_W'(i))
        cnt++;
    roots = PCOUNT_W'(cnt);
    forest_clear();
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatch_count < MAX_REPORTS)
      $display("[%0t] mismatch: %s", $realtime, what);
    mismatch_count++;
  endtask

  // Send one entry; idle the sender first at the given rate per cycle.
  // A negative fixed count means the forest model decides the count.
  task automatic issue_entry(input logic [IDX_W-1:0] r, input logic [IDX_W-1:0] c,
                             input logic conn, input logic lst, input int idle_pct,
                             input int fixed_count);
    logic [PCOUNT_W-1:0] roots;
    while (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start     <= 1'b1;
    row       <= r;
    col       <= c;
    connected <= conn;
    last      <= lst;
    do @(posedge clk); while (busy);
    if (absorb_entry(r, c, conn, lst, roots)) begin
      pending_counts[pend_wr % PEND_DEPTH] = (fixed_count < 0) ? roots
                                                               : PCOUNT_W'(fixed_count);
      pend_wr++;
    end
  endtask

  // Drop start, let the core go idle, then write the vertex count
  task automatic write_vertex_count(input logic [VC_W-1:0] vc);
    start <= 1'b0;
    while (pend_wr != pend_rd)
      @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    cfg_valid    <= 1'b1;
    vertex_count <= vc;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    loaded_vc = vc;
  endtask

  // Send a graph of random entries, mostly in range, closed by a last mark when with_last is set
  task automatic issue_graph(input int idle_pct, input logic with_last);
    int n;
    int len;
    logic [IDX_W-1:0] r;
    logic [IDX_W-1:0] c;
    n = active_vertices();
    len = $urandom_range(1, (n > 0) ? ((2 * n + 1 < 40) ? 2 * n + 1 : 40) : 6);
    for (int k = 0; k < len; k++) begin
      r = (n > 0 && $urandom_range(0, 99) < 85) ? IDX_W'($urandom_range(0, n - 1))
                                                : IDX_W'($urandom_range(0, 255));
      c = (n > 0 && $urandom_range(0, 99) < 85) ? IDX_W'($urandom_range(0, n - 1))
                                                : IDX_W'($urandom_range(0, 255));
      issue_entry(r, c, $urandom_range(0, 99) < 80, with_last && (k == len - 1),
                  idle_pct, -1);
      random_sent++;
    end
  endtask

  // Check each reported count against the oldest pending one
  always @(posedge clk) begin
    if (!rst && done === 1'b1) begin
      if (pend_wr == pend_rd) begin
        report_mismatch($sformatf("province_count %0d with no count pending",
                                  province_count));
      end else begin
        if (province_count !== pending_counts[pend_rd % PEND_DEPTH])
          report_mismatch($sformatf("province_count got %0d want %0d",
                                    province_count,
                                    pending_counts[pend_rd % PEND_DEPTH]));
        pend_rd++;
      end
    end
  end

  // Stimulus
  initial begin
    int phase;
    int idle_pct;
    int pick;
    logic [VC_W-1:0] vc;
    phase = 0;
    loaded_vc = VC_RESET;
    forest_clear();

    // hold reset, then release it
    repeat (RESET_CYC) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // walk the directed table with no idling
    foreach (directed_entries[i]) begin
      if (directed_entries[i].wr_vc)
        write_vertex_count(directed_entries[i].vc);
      issue_entry(directed_entries[i].r, directed_entries[i].c,
                  directed_entries[i].conn, directed_entries[i].lst, 0,
                  directed_entries[i].fixed ? int'(directed_entries[i].want) : -1);
    end

    // random graphs in phases; each phase drains before the next write
    while (random_sent < RAND_ITEMS) begin
      case (phase % 3)
        0:       idle_pct = 0;
        1:       idle_pct = 58;
        default: idle_pct = 11;
      endcase
      pick = $urandom_range(0, 99);
      if (phase == 0)
        vc = VC_W'(NV);
      else if (phase == 1)
        vc = 9'd511;
      else if (pick < 40)
        vc = VC_W'($urandom_range(1, 16));
      else if (pick < 70)
        vc = VC_W'($urandom_range(17, 256));
      else if (pick < 78)
        vc = '0;
      else if (pick < 88)
        vc = VC_W'($urandom_range(257, 511));
      else
        vc = VC_W'(NV);
      write_vertex_count(vc);
      repeat ($urandom_range(2, 6)) issue_graph(idle_pct, 1'b1);
      // leave a graph open now and then so the next count lands mid-graph
      if ($urandom_range(0, 3) == 0)
        issue_graph(idle_pct, 1'b0);
      phase++;
    end

    // close any open graph, then wait out every pending count
    issue_entry('0, '0, 1'b0, 1'b1, 0, -1);
    start <= 1'b0;
    while (pend_wr != pend_rd)
      @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);

    if (mismatch_count == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

  // Watchdog
  initial begin
    #(LIMIT_NS);
    $display("FAILED: results differ");
    $finish;
  end

endmodule
